// ----- hdl/frb_pkg.sv -----
// Shared types and constants of the frame ring buffer.
package frb_pkg;

  localparam int SLOT_COUNT_DEF  = 64;
  localparam int SLOT_BYTES_DEF  = 250;
  localparam int QUEUE_DEPTH_DEF = 4;

  // widest slot index over the supported slot counts (up to 1024)
  localparam int SLOT_IDX_MAX_W = 10;
  localparam int MAC_W          = 48;
  localparam int BYTE_W         = 8;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_FULL_DROP = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_DELIVERED = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_DISABLED  = 3'd6
  } status_t;

  // what the back end does with the slot stores for one item
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_MAC_WR  = 2'd1,
    ACT_BYTE_WR = 2'd2,
    ACT_BYTE_RD = 2'd3
  } action_t;

  typedef struct packed {
    action_t                   action;
    status_t                   status;
    logic [SLOT_IDX_MAX_W-1:0] slot;
    logic [BYTE_W-1:0]         cursor;
    logic [MAC_W-1:0]          mac;
    logic [BYTE_W-1:0]         data;
    logic [BYTE_W-1:0]         length;
    logic                      last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- hdl/frb_front.sv -----
// Front end: accepts items, tracks ring pointers and classifies each item.
module frb_front #(
  parameter int SLOT_COUNT = frb_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = frb_pkg::SLOT_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [1:0]                   in_opcode,
  input  logic [frb_pkg::MAC_W-1:0]    in_sender_mac,
  input  logic [frb_pkg::BYTE_W-1:0]   in_frame_length,
  input  logic [frb_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  output logic                         push,
  output frb_pkg::entry_t              entry
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOT_COUNT - 1);
  localparam logic [frb_pkg::BYTE_W-1:0] MAX_LEN = frb_pkg::BYTE_W'(SLOT_BYTES);

  logic [IDX_W-1:0]          head_slot_r, head_slot_nxt;
  logic                      head_wrap_r, head_wrap_nxt;
  logic [IDX_W-1:0]          tail_slot_r, tail_slot_nxt;
  logic                      tail_wrap_r, tail_wrap_nxt;
  logic [frb_pkg::BYTE_W-1:0] wr_cursor_r, wr_cursor_nxt;
  logic                      wr_active_r, wr_active_nxt;
  logic [frb_pkg::BYTE_W-1:0] rd_cursor_r, rd_cursor_nxt;
  logic [frb_pkg::BYTE_W-1:0] open_len_r, open_len_nxt;
  logic                      enabled_r;
  logic [frb_pkg::BYTE_W-1:0] tail_len_r;
  logic                      len_wr_en;

  logic [frb_pkg::BYTE_W-1:0] length_store [SLOT_COUNT];

  logic                      ring_full, ring_empty;
  logic [frb_pkg::BYTE_W-1:0] wr_step, rd_step;

  assign ring_full  = (head_slot_r == tail_slot_r) && (head_wrap_r != tail_wrap_r);
  assign ring_empty = (head_slot_r == tail_slot_r) && (head_wrap_r == tail_wrap_r);
  assign wr_step    = wr_cursor_r + frb_pkg::BYTE_W'(1);
  assign rd_step    = rd_cursor_r + frb_pkg::BYTE_W'(1);

  always_comb begin
    head_slot_nxt = head_slot_r;
    head_wrap_nxt = head_wrap_r;
    tail_slot_nxt = tail_slot_r;
    tail_wrap_nxt = tail_wrap_r;
    wr_cursor_nxt = wr_cursor_r;
    wr_active_nxt = wr_active_r;
    rd_cursor_nxt = rd_cursor_r;
    open_len_nxt  = open_len_r;
    len_wr_en     = 1'b0;
    entry         = '0;
    entry.action  = frb_pkg::ACT_NONE;
    entry.status  = frb_pkg::ST_IGNORED;
    if (accept) begin
      case (frb_pkg::opcode_t'(in_opcode))
        frb_pkg::OP_START: begin
          wr_active_nxt = 1'b0;
          if (in_frame_length == '0 || in_frame_length > MAX_LEN) begin
            entry.status = frb_pkg::ST_BAD_LEN;
          end else if (ring_full) begin
            entry.status = frb_pkg::ST_FULL_DROP;
          end else begin
            len_wr_en     = 1'b1;
            open_len_nxt  = in_frame_length;
            wr_cursor_nxt = '0;
            wr_active_nxt = 1'b1;
            entry.action  = frb_pkg::ACT_MAC_WR;
            entry.slot    = frb_pkg::SLOT_IDX_MAX_W'(head_slot_r);
            entry.mac     = in_sender_mac;
            entry.status  = frb_pkg::ST_ACCEPTED;
          end
        end
        frb_pkg::OP_DATA: begin
          if (wr_active_r) begin
            entry.action  = frb_pkg::ACT_BYTE_WR;
            entry.slot    = frb_pkg::SLOT_IDX_MAX_W'(head_slot_r);
            entry.cursor  = wr_cursor_r;
            entry.data    = in_data_byte;
            entry.status  = frb_pkg::ST_ACCEPTED;
            wr_cursor_nxt = wr_step;
            if (wr_step >= open_len_r) begin
              // frame complete: publish the slot
              wr_cursor_nxt = '0;
              wr_active_nxt = 1'b0;
              if (head_slot_r == SLOT_LAST) begin
                head_slot_nxt = '0;
                head_wrap_nxt = ~head_wrap_r;
              end else begin
                head_slot_nxt = head_slot_r + IDX_W'(1);
              end
            end
          end
        end
        frb_pkg::OP_DRAIN: begin
          if (!enabled_r) begin
            entry.status = frb_pkg::ST_DISABLED;
          end else if (ring_empty) begin
            entry.status = frb_pkg::ST_EMPTY;
          end else begin
            entry.action  = frb_pkg::ACT_BYTE_RD;
            entry.slot    = frb_pkg::SLOT_IDX_MAX_W'(tail_slot_r);
            entry.cursor  = rd_cursor_r;
            entry.length  = tail_len_r;
            entry.status  = frb_pkg::ST_DELIVERED;
            rd_cursor_nxt = rd_step;
            if (rd_step >= tail_len_r) begin
              entry.last    = 1'b1;
              rd_cursor_nxt = '0;
              if (tail_slot_r == SLOT_LAST) begin
                tail_slot_nxt = '0;
                tail_wrap_nxt = ~tail_wrap_r;
              end else begin
                tail_slot_nxt = tail_slot_r + IDX_W'(1);
              end
            end
          end
        end
        default: begin
          entry.status = frb_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_slot_r <= '0;
      head_wrap_r <= 1'b0;
      tail_slot_r <= '0;
      tail_wrap_r <= 1'b0;
      wr_cursor_r <= '0;
      wr_active_r <= 1'b0;
      rd_cursor_r <= '0;
      enabled_r   <= 1'b0;
    end else begin
      head_slot_r <= head_slot_nxt;
      head_wrap_r <= head_wrap_nxt;
      tail_slot_r <= tail_slot_nxt;
      tail_wrap_r <= tail_wrap_nxt;
      wr_cursor_r <= wr_cursor_nxt;
      wr_active_r <= wr_active_nxt;
      rd_cursor_r <= rd_cursor_nxt;
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    open_len_r <= open_len_nxt;
  end

  // length of the tail slot, read ahead from the next tail index
  always_ff @(posedge clk) begin
    if (len_wr_en) begin
      length_store[head_slot_r] <= in_frame_length;
    end
    tail_len_r <= length_store[tail_slot_nxt];
  end

endmodule

// ----- hdl/frb_queue.sv -----
// Short register queue between the front and back ends.
module frb_queue #(
  parameter int DEPTH = frb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  frb_pkg::entry_t        wr_entry,
  input  logic                   pop,
  output frb_pkg::entry_t        rd_entry,
  output frb_pkg::queue_status_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frb_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign rd_entry   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ----- hdl/frb_back.sv -----
// Back end: slot MAC address and payload stores, read stage and output register.
module frb_back #(
  parameter int SLOT_COUNT = frb_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  frb_pkg::entry_t            q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [frb_pkg::BYTE_W-1:0] out_byte,
  output logic [frb_pkg::MAC_W-1:0]  out_mac,
  output logic [frb_pkg::BYTE_W-1:0] out_length,
  output logic                       out_last_of_frame
);

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int ADDR_W = IDX_W + frb_pkg::BYTE_W;

  logic [frb_pkg::BYTE_W-1:0] payload_store [SLOT_COUNT * (2 ** frb_pkg::BYTE_W)];
  logic [frb_pkg::MAC_W-1:0]  mac_store     [SLOT_COUNT];

  logic [IDX_W-1:0]  q_slot;
  logic [ADDR_W-1:0] q_addr;

  logic                       s1_valid_r;
  frb_pkg::entry_t            s1_entry_r;
  logic [frb_pkg::BYTE_W-1:0] rd_byte_r;
  logic [frb_pkg::MAC_W-1:0]  rd_mac_r;

  logic                       out_valid_r;
  logic [2:0]                 out_status_r;
  logic [frb_pkg::BYTE_W-1:0] out_byte_r;
  logic [frb_pkg::MAC_W-1:0]  out_mac_r;
  logic [frb_pkg::BYTE_W-1:0] out_length_r;
  logic                       out_last_r;

  logic out_adv, s1_adv;

  assign q_slot  = q_entry.slot[IDX_W-1:0];
  assign q_addr  = {q_slot, q_entry.cursor};
  assign out_adv = !out_valid_r || !out_stall;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign q_pop   = q_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_entry.action)
        frb_pkg::ACT_MAC_WR:  mac_store[q_slot] <= q_entry.mac;
        frb_pkg::ACT_BYTE_WR: payload_store[q_addr] <= q_entry.data;
        default: ;
      endcase
      rd_byte_r  <= payload_store[q_addr];
      rd_mac_r   <= mac_store[q_slot];
      s1_entry_r <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= q_pop;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_status_r <= s1_entry_r.status;
      if (s1_entry_r.action == frb_pkg::ACT_BYTE_RD) begin
        out_byte_r   <= rd_byte_r;
        out_mac_r    <= rd_mac_r;
        out_length_r <= s1_entry_r.length;
        out_last_r   <= s1_entry_r.last;
      end else begin
        out_byte_r   <= '0;
        out_mac_r    <= '0;
        out_length_r <= '0;
        out_last_r   <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_byte          = out_byte_r;
  assign out_mac           = out_mac_r;
  assign out_length        = out_length_r;
  assign out_last_of_frame = out_last_r;

endmodule

// ----- hdl/frame_ring_buffer_drop_on_full.sv -----
// Top level of the frame ring buffer with drop on full.
//
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  opcode, sender_mac, frame_length, data_byte
// out_      output     out_valid/out_stall  status, byte, mac, length, last_of_frame
// cfg_      input      cfg_wr_en            cfg_wr_data (delivery enable)
//
// One item per cycle sustained while in_stall is low; every item gives exactly one result item.
// The front end updates all ring pointers in the cycle an item is taken, so
// the rate is set by that single pointer-update step and the one-port stores.
// From accept, an item passes the queue, the read stage register and the output register.
// Reset clears pointers, cursors and the enable; slot stores are not cleared
// and need no clearing pass, since only fully written slots are ever drained.
// in_stall rises only when the front-to-back queue is full (out_stall held).
module frame_ring_buffer_drop_on_full #(
  parameter int SLOT_COUNT  = frb_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES  = frb_pkg::SLOT_BYTES_DEF,
  parameter int QUEUE_DEPTH = frb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [frb_pkg::MAC_W-1:0]  in_sender_mac,
  input  logic [frb_pkg::BYTE_W-1:0] in_frame_length,
  input  logic [frb_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [frb_pkg::BYTE_W-1:0] out_byte,
  output logic [frb_pkg::MAC_W-1:0]  out_mac,
  output logic [frb_pkg::BYTE_W-1:0] out_length,
  output logic                       out_last_of_frame,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data
);

  logic                   accept;
  logic                   push;
  logic                   pop;
  frb_pkg::entry_t        fe_entry;
  frb_pkg::entry_t        q_entry;
  frb_pkg::queue_status_t q_stat;

  // stall only on a full queue, never on the input valid
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  frb_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_opcode       (in_opcode),
    .in_sender_mac   (in_sender_mac),
    .in_frame_length (in_frame_length),
    .in_data_byte    (in_data_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push            (push),
    .entry           (fe_entry)
  );

  frb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (fe_entry),
    .pop      (pop),
    .rd_entry (q_entry),
    .stat     (q_stat)
  );

  frb_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (!q_stat.empty),
    .q_entry           (q_entry),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_mac           (out_mac),
    .out_length        (out_length),
    .out_last_of_frame (out_last_of_frame)
  );

  // an accepted item always lands in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // only delivered bytes carry frame fields
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != frb_pkg::ST_DELIVERED) |->
      (out_byte == '0 && out_mac == '0 && out_length == '0 && !out_last_of_frame))
    else $error("frame fields set on a non-delivery result");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

endmodule

// ----- tb/sv/frb_checker.sv -----
// Checker for the frame ring buffer: predicts every result item and compares it.
module frb_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [frb_pkg::MAC_W-1:0]  in_sender_mac,
  input  logic [frb_pkg::BYTE_W-1:0] in_frame_length,
  input  logic [frb_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [2:0]                 out_status,
  input  logic [frb_pkg::BYTE_W-1:0] out_byte,
  input  logic [frb_pkg::MAC_W-1:0]  out_mac,
  input  logic [frb_pkg::BYTE_W-1:0] out_length,
  input  logic                       out_last_of_frame,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  output int                         errors,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import frb_pkg::*;

  localparam int SLOTS  = SLOT_COUNT_DEF;
  localparam int STRIDE = 256;
  localparam int CNT_W  = $clog2(2 * SLOTS);

  typedef struct {
    status_t           status;
    logic [BYTE_W-1:0] data;
    logic [MAC_W-1:0]  mac;
    logic [BYTE_W-1:0] length;
    logic              last;
  } ring_result_t;

  // shadow ring
  logic [BYTE_W-1:0] payload_mem [SLOTS*STRIDE];
  logic [MAC_W-1:0]  mac_mem [SLOTS];
  logic [BYTE_W-1:0] len_mem [SLOTS];
  logic [CNT_W-1:0]  head_cnt, tail_cnt;
  logic [BYTE_W-1:0] wr_pos, rd_pos;
  logic              frame_open;
  logic              deliver_en;

  ring_result_t due_results [$];

  // one item through the shadow ring; returns the result it should produce
  function automatic ring_result_t advance_ring(opcode_t op, logic [MAC_W-1:0] mac,
                                                logic [BYTE_W-1:0] len,
                                                logic [BYTE_W-1:0] b);
    ring_result_t r;
    int slot;
    r = '{ST_IGNORED, '0, '0, '0, 1'b0};
    case (op)
      OP_START: begin
        frame_open = 1'b0;
        if (len == 0 || len > SLOT_BYTES_DEF) begin
          r.status = ST_BAD_LEN;
        end else if (CNT_W'(head_cnt - tail_cnt) >= SLOTS) begin
          r.status = ST_FULL_DROP;
        end else begin
          slot = head_cnt % SLOTS;
          mac_mem[slot] = mac;
          len_mem[slot] = len;
          wr_pos = '0;
          frame_open = 1'b1;
          r.status = ST_ACCEPTED;
        end
      end
      OP_DATA: begin
        if (frame_open) begin
          slot = head_cnt % SLOTS;
          payload_mem[slot*STRIDE + wr_pos] = b;
          wr_pos = wr_pos + 1'b1;
          if (wr_pos >= len_mem[slot]) begin
            head_cnt = head_cnt + 1'b1;
            frame_open = 1'b0;
            wr_pos = '0;
          end
          r.status = ST_ACCEPTED;
        end
      end
      OP_DRAIN: begin
        if (!deliver_en) begin
          r.status = ST_DISABLED;
        end else if (head_cnt == tail_cnt) begin
          r.status = ST_EMPTY;
        end else begin
          slot = tail_cnt % SLOTS;
          r.status = ST_DELIVERED;
          r.data   = payload_mem[slot*STRIDE + rd_pos];
          r.mac    = mac_mem[slot];
          r.length = len_mem[slot];
          rd_pos = rd_pos + 1'b1;
          if (rd_pos >= r.length) begin
            r.last = 1'b1;
            rd_pos = '0;
            tail_cnt = tail_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string what, logic [MAC_W-1:0] want, logic [MAC_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t frb_checker: %s mismatch, expected %h, actual %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    if (!rst_n) begin
      head_cnt   = '0;
      tail_cnt   = '0;
      wr_pos     = '0;
      rd_pos     = '0;
      frame_open = 1'b0;
      deliver_en = 1'b0;
      due_results.delete();
    end else begin
      // results first, so a stray result never pairs with an item taken this edge
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t frb_checker: result with none expected, expected nothing, actual %h",
                   $realtime, out_status);
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("byte", want.data, out_byte);
          check_field("mac", want.mac, out_mac);
          check_field("length", want.length, out_length);
          check_field("last", want.last, out_last_of_frame);
        end
      end
      if (cfg_wr_en) deliver_en = cfg_wr_data;
      if (in_valid && !in_stall)
        due_results.push_back(advance_ring(opcode_t'(in_opcode), in_sender_mac,
                                           in_frame_length, in_data_byte));
    end
    outstanding <= due_results.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Stimulus and verdict for the frame ring buffer with drop on full.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import frb_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_opcode = OP_UNUSED;
  logic [MAC_W-1:0]    in_sender_mac = '0;
  logic [BYTE_W-1:0]   in_frame_length = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          out_status;
  logic [BYTE_W-1:0]   out_byte;
  logic [MAC_W-1:0]    out_mac;
  logic [BYTE_W-1:0]   out_length;
  logic                out_last_of_frame;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;

  int errors;
  int outstanding;

  // 1 in idle_odds chance per item (1 in twice idle_odds per cycle on the result side) to start
  // an idle burst; 0 turns idling off on both sides
  int idle_odds = 0;
  int stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frame_ring_buffer_drop_on_full u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_sender_mac     (in_sender_mac),
    .in_frame_length   (in_frame_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_mac           (out_mac),
    .out_length        (out_length),
    .out_last_of_frame (out_last_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  frb_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_sender_mac     (in_sender_mac),
    .in_frame_length   (in_frame_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_mac           (out_mac),
    .out_length        (out_length),
    .out_last_of_frame (out_last_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .errors            (errors),
    .outstanding       (outstanding)
  );

  // Result side back-pressure: stall bursts of random length.
  always @(posedge clk) begin
    if (!rst_n || idle_odds == 0) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(1, idle_odds * 2) == 1) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Offer one item and hold it until taken. Called at a rising edge; valid
  // stays high across back-to-back items, so it only drops for a gap.
  task automatic push(opcode_t op, logic [MAC_W-1:0] mac, logic [BYTE_W-1:0] len,
                      logic [BYTE_W-1:0] b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_sender_mac   <= mac;
    in_frame_length <= len;
    in_data_byte    <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender quiet until the checker holds no open expectation, plus a margin
  // for the pipeline. Outstanding is registered, hence
  // the first wait.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the ring pipeline empty.
  task automatic set_delivery(logic en);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // start item plus nbytes data items
  task automatic send_frame(logic [BYTE_W-1:0] len, int nbytes);
    push(OP_START, rand_mac(), len, 8'($urandom));
    repeat (nbytes) push(OP_DATA, rand_mac(), 8'($urandom), 8'($urandom));
  endtask

  // One random phase. Well-formed frames of short length with the odd
  // long one, runs of drains, and some noise: bad lengths, stray bytes,
  // the unused opcode, and frames cut short then abandoned by the next start.
  task automatic run_phase(int budget, int prod_pct, int drain_pct, int small_max);
    int done_items;
    int pick;
    int len;
    int nb;
    done_items = 0;
    while (done_items < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < prod_pct) begin
        if ($urandom_range(0, 99) == 0)
          len = $urandom_range(100, SLOT_BYTES_DEF);
        else
          len = $urandom_range(1, small_max);
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
        send_frame(8'(len), nb);
        done_items += nb + 1;
      end else if (pick < prod_pct + drain_pct) begin
        nb = $urandom_range(1, 8);
        repeat (nb) push(OP_DRAIN, rand_mac(), 8'($urandom), 8'($urandom));
        done_items += nb;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            // bad length: zero or past the slot size
            len = $urandom_range(0, 1) ? 0 : $urandom_range(SLOT_BYTES_DEF + 1, 255);
            push(OP_START, rand_mac(), 8'(len), 8'($urandom));
            done_items++;
          end
          1: begin
            push(OP_DATA, rand_mac(), 8'($urandom), 8'($urandom));
            done_items++;
          end
          2: begin
            push(OP_UNUSED, rand_mac(), 8'($urandom), 8'($urandom));
            done_items++;
          end
          default: begin
            // any announced length at all
            push(OP_START, rand_mac(), 8'($urandom), 8'($urandom));
            done_items++;
          end
        endcase
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, delivery off ----
    idle_odds = 4;
    set_delivery(1'b0);
    push(OP_DRAIN, '1, '1, '1);                      // drain while disabled
    push(OP_DATA, '0, '0, 8'hA5);                    // byte with no open frame
    push(OP_UNUSED, '1, 8'hFF, 8'hFF);               // unused opcode
    push(OP_START, rand_mac(), 8'd0, '0);            // zero length
    push(OP_START, rand_mac(), 8'd251, '0);          // one past slot size
    push(OP_START, '0, 8'd255, '1);                  // largest field value
    push(OP_START, '1, 8'd1, '0);                    // one-byte frame, all-ones mac
    push(OP_DATA, '0, '0, 8'hFF);
    push(OP_START, 48'h0123_4567_89AB, 8'd2, '0);    // opened, then abandoned
    push(OP_DATA, '1, '1, 8'h00);
    push(OP_START, 48'hFEDC_BA98_7654, 8'd3, '0);    // restart reuses the slot
    push(OP_DATA, '0, '0, 8'h01);
    push(OP_DATA, '0, '0, 8'h02);
    push(OP_DATA, '0, '0, 8'h03);
    push(OP_DATA, '0, '0, 8'h55);                    // frame closed, ignored
    wait_drained();

    // ---- directed part, delivery on: both frames out, then empty ----
    set_delivery(1'b1);
    repeat (4) push(OP_DRAIN, rand_mac(), 8'($urandom), 8'($urandom));
    push(OP_DRAIN, '0, '0, '0);
    wait_drained();

    // ---- random part ----
    // one full-size frame out and back
    idle_odds = 3;
    send_frame(8'(SLOT_BYTES_DEF), SLOT_BYTES_DEF);
    run_phase(180, 50, 40, 6);

    // consumer off, tiny frames: the ring fills and starts dropping
    set_delivery(1'b0);
    idle_odds = 5;
    run_phase(260, 90, 5, 2);

    // consumer back, drain-heavy, no idling at all
    set_delivery(1'b1);
    idle_odds = 0;
    run_phase(180, 20, 75, 6);

    idle_odds = 2;
    set_delivery(1'b1);
    run_phase(180, 70, 25, 3);

    set_delivery(1'b0);
    idle_odds = 4;
    run_phase(160, 60, 30, 6);

    set_delivery(1'b1);
    idle_odds = 3;
    run_phase(180, 45, 45, 6);

    // last stretch without idling, mostly draining
    idle_odds = 0;
    run_phase(160, 10, 85, 6);

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/frb_pkg.sv
hdl/frb_front.sv
hdl/frb_queue.sv
hdl/frb_back.sv
hdl/frame_ring_buffer_drop_on_full.sv
tb/sv/frb_checker.sv
tb/sv/tb_top.sv
